// ----- design/mnos_pkg.sv -----
// package for the note-off scheduler: result kinds, ops, widths, sizes
// no dependencies
`default_nettype none
package mnos_pkg;
  localparam int SLOTS_DEF = 32;
  localparam logic [1:0] OP_NOTE = 2'd0;
  localparam logic [1:0] OP_OTHER = 2'd1;
  localparam logic [1:0] OP_END = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [2:0] K_ON = 3'd0;
  localparam logic [2:0] K_OFF = 3'd1;
  localparam logic [2:0] K_OTHER = 3'd2;
  localparam logic [2:0] K_END = 3'd3;
  localparam logic [2:0] K_DROP = 3'd4;
  localparam logic CFG_MERGE = 1'b0;
  localparam logic CFG_START = 1'b1;
  localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;

  // one result waiting for transfer
  typedef struct packed {
    logic [2:0] kind;
    logic [30:0] delta;
    logic [6:0] pitch;
    logic [31:0] word;
    logic err;
    logic last;
  } res_t;

  // clamped delta from prev to tick
  function automatic logic [31:0] clamp_delta(input logic signed [31:0] tick,
                                              input logic signed [31:0] prev);
    logic signed [32:0] d;
    logic [31:0] r;
    begin
      d = 33'(tick) - 33'(prev);
      if (d < 0) r = {1'b1, 31'd0};
      else if (d > 33'sh7fffffff) r = {1'b0, 31'h7fffffff};
      else r = {1'b0, d[30:0]};
      clamp_delta = r;
    end
  endfunction
endpackage
`default_nettype wire

// ----- design/mnos_outreg.sv -----
// output register stage holding one result until transfer
// depends on mnos_pkg
`default_nettype none
module mnos_outreg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mnos_pkg::res_t  din,
  output logic                 full,
  input  wire logic            pop,
  output mnos_pkg::res_t       dout
);
  // hold register, refilled by the sequencer only when empty
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
      dout <= din;
    end else if (pop) begin
      full <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- design/midi_note_off_scheduler_unit.sv -----
// top level of the note-off scheduler: slot table, scan sequencer, output stage
// depends on mnos_pkg and mnos_outreg
`default_nettype none
// One item is accepted at a time; in_stall is high from the accepting edge until the
// item's last result has entered the output register. Each scan walks the slot table
// one entry per cycle; the due scans use a single shared compare unit. After the
// accepting edge an item runs one due scan per due note-off plus a final one, each
// ending in an emit step. A note then runs a pitch search, a merge or interrupt step,
// a free-slot search and an enter step; a merge ends the item without the free-slot
// search, and a note of zero length skips both searches. A pass-through event or end
// mark takes one emit step. A closing step ends every item. A result also waits while
// the output register is still full. Items with the unused op are accepted and dropped without any work.
module midi_note_off_scheduler_unit #(
  parameter int SLOTS = mnos_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] now_tick,
  input  wire logic [6:0]  pitch,
  input  wire logic [23:0] length_ticks,
  input  wire logic [31:0] event_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [30:0]      out_delta,
  output logic [6:0]       out_pitch,
  output logic [31:0]      out_word,
  output logic             time_error,
  output logic             last
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DUE, S_DUE_EMIT, S_PSCAN, S_PHIT, S_FSCAN, S_FEMIT, S_TAIL, S_FIN
  } state_t;

  // slot table
  logic [SLOTS-1:0] slot_valid;
  logic [6:0] slot_pitch [SLOTS];
  logic signed [31:0] slot_stop [SLOTS];
  logic signed [31:0] slot_begin [SLOTS];
  logic [15:0] slot_order [SLOTS];
  logic [15:0] insert_count;
  logic signed [31:0] prev_tick;
  logic merge_unisons;

  // item registers
  state_t state;
  logic [1:0] r_op;
  logic signed [31:0] r_now, r_stop, limit;
  logic [6:0] r_pitch;
  logic [31:0] r_word;
  logic r_skip;
  logic [IW-1:0] idx, best;
  logic best_ok;
  logic found;
  logic [IW:0] cnt;

  // held result and output stage
  mnos_pkg::res_t pend, pend_out, dout;
  logic pend_ok;
  logic full;

  // shared compare unit: entry idx against current best
  logic signed [31:0] e_stop, b_stop;
  logic [15:0] age_e, age_b;
  logic e_due, e_better;
  assign e_stop = slot_stop[idx];
  assign b_stop = slot_stop[best];
  assign age_e = insert_count - slot_order[idx];
  assign age_b = insert_count - slot_order[best];
  assign e_due = slot_valid[idx] && (e_stop <= limit);
  assign e_better = !best_ok || (e_stop < b_stop) ||
                    ((e_stop == b_stop) && (age_e > age_b));

  logic signed [32:0] stop_sum;
  assign stop_sum = 33'(signed'(now_tick)) + 33'(length_ticks);

  logic scan_end;
  assign scan_end = (cnt == (IW+1)'(SLOTS - 1));

  // pending entry of the same pitch is merged rather than interrupted when it began at this tick or unisons merge
  logic hit_merge;
  assign hit_merge = (slot_begin[idx] == r_now) || merge_unisons;

  // delta of the result being formed
  logic signed [31:0] emit_tick;
  logic [31:0] cd;
  assign emit_tick = (state == S_DUE_EMIT) ? b_stop : r_now;
  assign cd = mnos_pkg::clamp_delta(emit_tick, prev_tick);

  // states that form a result this cycle
  logic emit_req;
  always_comb begin
    unique case (state) inside
      S_DUE_EMIT: emit_req = best_ok;
      S_PHIT: emit_req = !hit_merge;
      S_FEMIT, S_TAIL: emit_req = 1'b1;
      default: emit_req = 1'b0;
    endcase
  end

  // a new result may be formed once the held one can move on
  logic room, opush;
  assign room = !pend_ok || !full;
  assign opush = pend_ok && !full && (emit_req || state == S_FIN);

  // held result is the last one of its item when it leaves at the closing cycle
  always_comb begin
    pend_out = pend;
    pend_out.last = (state == S_FIN);
  end

  // sequencer, table and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      insert_count <= '0;
      prev_tick <= '0;
      merge_unisons <= 1'b0;
      pend_ok <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mnos_pkg::CFG_MERGE: merge_unisons <= cfg_data[0];
          mnos_pkg::CFG_START: prev_tick <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_op <= op; r_now <= now_tick; r_pitch <= pitch; r_word <= event_word;
            r_skip <= (length_ticks == 24'd0);
            r_stop <= (stop_sum > 33'(mnos_pkg::INT_MAX)) ? mnos_pkg::INT_MAX
                                                        : stop_sum[31:0];
            limit <= (op == mnos_pkg::OP_END) ? mnos_pkg::INT_MAX : now_tick;
            idx <= '0; cnt <= '0; best_ok <= 1'b0; best <= '0; found <= 1'b0;
            if (op != mnos_pkg::OP_NONE) state <= S_DUE;
          end
        end
        S_DUE: begin
          if (e_due && e_better) begin
            best <= idx; best_ok <= 1'b1;
          end
          idx <= idx + 1'b1; cnt <= cnt + 1'b1;
          if (scan_end) state <= S_DUE_EMIT;
        end
        S_DUE_EMIT: begin
          idx <= '0; cnt <= '0;
          if (best_ok) begin
            if (room) begin
              pend <= '{mnos_pkg::K_OFF, cd[30:0], slot_pitch[best], 32'd0, cd[31], 1'b0};
              pend_ok <= 1'b1;
              prev_tick <= b_stop;
              slot_valid[best] <= 1'b0;
              best_ok <= 1'b0;
              state <= S_DUE;
            end
          end else if (r_op == mnos_pkg::OP_NOTE) begin
            state <= r_skip ? S_FIN : S_PSCAN;
          end else begin
            state <= S_TAIL;
          end
        end
        S_PSCAN: begin
          if (slot_valid[idx] && slot_pitch[idx] == r_pitch) begin
            state <= S_PHIT;
          end else if (scan_end) begin
            idx <= '0; cnt <= '0; state <= S_FSCAN;
          end else begin
            idx <= idx + 1'b1; cnt <= cnt + 1'b1;
          end
        end
        S_PHIT: begin
          if (hit_merge) begin
            if (slot_stop[idx] < r_stop) begin
              slot_stop[idx] <= r_stop;
              slot_order[idx] <= insert_count;
              insert_count <= insert_count + 1'b1;
            end
            state <= S_FIN;
          end else if (room) begin
            pend <= '{mnos_pkg::K_OFF, cd[30:0], slot_pitch[idx], 32'd0, cd[31], 1'b0};
            pend_ok <= 1'b1;
            prev_tick <= r_now;
            slot_valid[idx] <= 1'b0;
            if (slot_stop[idx] > r_stop) r_stop <= slot_stop[idx];
            idx <= '0; cnt <= '0;
            state <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (!slot_valid[idx]) begin
            found <= 1'b1;
            state <= S_FEMIT;
          end else if (scan_end) begin
            state <= S_FEMIT;
          end else begin
            idx <= idx + 1'b1; cnt <= cnt + 1'b1;
          end
        end
        S_FEMIT: begin
          if (room) begin
            pend_ok <= 1'b1;
            if (found) begin
              slot_valid[idx] <= 1'b1;
              slot_pitch[idx] <= r_pitch;
              slot_stop[idx] <= r_stop;
              slot_begin[idx] <= r_now;
              slot_order[idx] <= insert_count;
              insert_count <= insert_count + 1'b1;
              prev_tick <= r_now;
              pend <= '{mnos_pkg::K_ON, cd[30:0], r_pitch, 32'd0, cd[31], 1'b0};
            end else begin
              pend <= '{mnos_pkg::K_DROP, 31'd0, r_pitch, 32'd0, 1'b0, 1'b0};
            end
            state <= S_FIN;
          end
        end
        S_TAIL: begin
          if (room) begin
            pend_ok <= 1'b1;
            if (r_op == mnos_pkg::OP_OTHER) begin
              prev_tick <= r_now;
              pend <= '{mnos_pkg::K_OTHER, cd[30:0], 7'd0, r_word, cd[31], 1'b0};
            end else begin
              pend <= '{mnos_pkg::K_END, cd[30:0], 7'd0, 32'd0, cd[31], 1'b0};
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // held result leaves marked as last, then the item is done
          if (room) begin
            pend_ok <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mnos_outreg u_out (
    .clk(clk), .rst(rst), .push(opush), .din(pend_out), .full(full),
    .pop(out_valid && !out_stall), .dout(dout)
  );

  assign out_valid = full;
  assign kind = dout.kind;
  assign out_delta = dout.delta;
  assign out_pitch = dout.pitch;
  assign out_word = dout.word;
  assign time_error = dout.err;
  assign last = dout.last;
  assign in_stall = (state != S_IDLE);

  // checks
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_stall) |=> (out_valid && $stable(dout)))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst) opush |-> !full)
    else $error("push into busy stage");
  assert property (@(posedge clk) disable iff (rst)
                   (in_valid && !in_stall && op != mnos_pkg::OP_NONE) |=> in_stall)
    else $error("accepted item did not start");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> kind <= mnos_pkg::K_DROP)
    else $error("result kind out of range");
endmodule
`default_nettype wire
